@@ rtl/sli_pkg.sv @@
package sli_pkg;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = $clog2(Capacity + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                         write;
    op_e                          op;
    logic signed [ValueWidth-1:0] value;
  } cmd_t;

  // Signals that ripple from a cell to its right neighbor.
  typedef struct packed {
    logic below;  // this entry is occupied and smaller than the command value
    logic hit;    // a matching entry was found at or before this cell
  } link_t;

endpackage

@@ rtl/sli_cell.sv @@
module sli_cell (
  input  logic                                  clk_i,
  input  sli_pkg::cmd_t                         cmd_i,
  input  logic                                  occupied_i,
  input  logic signed [sli_pkg::ValueWidth-1:0] left_entry_i,
  input  logic signed [sli_pkg::ValueWidth-1:0] right_entry_i,
  input  sli_pkg::link_t                        link_i,
  output sli_pkg::link_t                        link_o,
  output logic signed [sli_pkg::ValueWidth-1:0] entry_o,
  output logic signed [sli_pkg::ValueWidth-1:0] entry_next_o
);

  logic signed [sli_pkg::ValueWidth-1:0] entry_q, entry_d;
  logic                                  below;
  logic                                  match;

  assign below = occupied_i && (entry_q < cmd_i.value);
  assign match = occupied_i && (entry_q == cmd_i.value);

  assign link_o.below = below;
  assign link_o.hit   = link_i.hit || match;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.write) begin
      if (cmd_i.op == sli_pkg::OP_INSERT) begin
        // Cells before the insert point keep, the insert point takes the value,
        // and everything after it moves one place to the right.
        if (!below) begin
          entry_d = link_i.below ? cmd_i.value : left_entry_i;
        end
      end else begin
        // From the first matching entry onward, everything moves left.
        if (link_i.hit || match) begin
          entry_d = right_entry_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign entry_next_o = entry_d;

endmodule

@@ rtl/sorted_list_insert_delete.sv @@
// Sorted list of signed values held in a chain of compare-and-shift cells.
// The result is registered and appears in the cycle after the input transaction.
// Throughput: one operation per cycle unless the output stalls; every cell decides in one step.
// The output register frees in the same cycle that its result is taken.
// Reset clears the entry count and the output valid flag; entries are not cleared.
module sorted_list_insert_delete (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  opcode_i,
  input  logic signed [sli_pkg::ValueWidth-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            status_o,
  output logic [4:0]                            entry_count_o,
  output logic signed [sli_pkg::ValueWidth-1:0] smallest_value_o
);

  localparam int unsigned N = sli_pkg::Capacity;
  localparam int unsigned CW = sli_pkg::CountWidth;

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [4:0]    entry_count_q;
  logic signed [sli_pkg::ValueWidth-1:0] smallest_q, smallest_d;

  logic          accept;
  logic          full;
  logic          found;
  sli_pkg::op_e  op;
  sli_pkg::cmd_t cmd;
  sli_pkg::status_e status_d;

  logic signed [sli_pkg::ValueWidth-1:0] entry      [N];
  logic signed [sli_pkg::ValueWidth-1:0] entry_next [N];
  sli_pkg::link_t                        link       [N+1];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = sli_pkg::op_e'(opcode_i);
  assign full       = (count_q == CW'(N));
  assign found      = link[N].hit;

  always_comb begin
    status_d = sli_pkg::ST_OK;
    count_d  = count_q;
    if (op == sli_pkg::OP_INSERT) begin
      if (full) begin
        status_d = sli_pkg::ST_FULL;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else begin
      if (!found) begin
        status_d = sli_pkg::ST_NOT_FOUND;
      end else begin
        count_d = count_q - CW'(1);
      end
    end
  end

  assign cmd.write = accept && (status_d == sli_pkg::ST_OK);
  assign cmd.op    = op;
  assign cmd.value = value_i;

  // The head of the chain behaves as if an occupied smaller entry stood before it.
  assign link[0].below = 1'b1;
  assign link[0].hit   = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [sli_pkg::ValueWidth-1:0] left_entry;
    logic signed [sli_pkg::ValueWidth-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_entry = value_i;
    end else begin : g_body
      assign left_entry = entry[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    sli_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (count_q > CW'(i)),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .link_i       (link[i]),
      .link_o       (link[i+1]),
      .entry_o      (entry[i]),
      .entry_next_o (entry_next[i])
    );
  end

  assign smallest_d = (count_d != '0) ? entry_next[0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      entry_count_q <= 5'(count_d);
      smallest_q    <= smallest_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_count_o    = entry_count_q;
  assign smallest_value_o = smallest_q;

endmodule
